// ===== design/spsub_pkg.sv =====
// Package for the stream pattern substitute block: sizes, register map,
// transaction and control types shared by all design files. No dependencies.
package spsub_pkg;

	localparam int MaxPattern = 16;
	localparam int HeldW      = 4;   // held byte count 0..MaxPattern-1
	localparam int CountW     = 5;   // byte count 0..MaxPattern
	localparam int AddrW      = 6;
	localparam int DataW      = 64;

	localparam logic [2:0] RegPatternLow  = 3'd0;
	localparam logic [2:0] RegPatternHigh = 3'd1;
	localparam logic [2:0] RegReplaceLow  = 3'd2;
	localparam logic [2:0] RegReplaceHigh = 3'd3;
	localparam logic [2:0] RegPatternLen  = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [MaxPattern-1:0][7:0] pattern;
		logic [MaxPattern-1:0][7:0] replace;
		logic [CountW-1:0]          length;   // clamped to 1..MaxPattern
	} cfg_t;

	typedef struct packed {
		logic                       valid;
		logic [MaxPattern-1:0][7:0] bytes;
		logic [CountW-1:0]          count;
		logic                       last;
	} burst_t;

endpackage

// ===== design/spsub_cfg.sv =====
// APB register file for pattern, replacement and pattern length.
// Depends on spsub_pkg.
module spsub_cfg import spsub_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [63:0]       pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
	logic [CountW-1:0] len_q;
	logic [2:0]        reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[AddrW-1:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			rep_lo_q <= '0;
			rep_hi_q <= '0;
			len_q    <= CountW'(1);
		end else if (wr_en) begin
			unique case (reg_idx)
				RegPatternLow:  pat_lo_q <= pwdata;
				RegPatternHigh: pat_hi_q <= pwdata;
				RegReplaceLow:  rep_lo_q <= pwdata;
				RegReplaceHigh: rep_hi_q <= pwdata;
				RegPatternLen:  len_q    <= pwdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegPatternLow:  prdata = pat_lo_q;
			RegPatternHigh: prdata = pat_hi_q;
			RegReplaceLow:  prdata = rep_lo_q;
			RegReplaceHigh: prdata = rep_hi_q;
			RegPatternLen:  prdata = {{(DataW-CountW){1'b0}}, len_q};
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		cfg.pattern = {pat_hi_q, pat_lo_q};
		cfg.replace = {rep_hi_q, rep_lo_q};
		if (len_q == '0)
			cfg.length = CountW'(1);
		else if (len_q > CountW'(MaxPattern))
			cfg.length = CountW'(MaxPattern);
		else
			cfg.length = len_q;
	end

endmodule

// ===== design/spsub_core.sv =====
// Input register, sliding window, pattern compare and replacement.
// Produces one burst of output bytes per input transaction. Depends on spsub_pkg.
module spsub_core import spsub_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  cfg_t     cfg,
	input  logic     obuf_free,
	output burst_t   burst
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic [MaxPattern-1:0][7:0] win_q;
	logic [HeldW-1:0]  held_q;

	logic              load;
	logic [MaxPattern-1:0][7:0] wr, nw, sh;
	logic [CountW-1:0] count, emit;
	logic [HeldW-1:0]  start, idx, off;
	logic              full, match;
	logic [MaxPattern-1:0] neq;

	assign load     = valid_s1 && obuf_free;
	assign in_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_data.in_byte;
			last_s1 <= in_data.in_last;
		end
	end

	always_comb begin
		count = CountW'(held_q) + CountW'(1);
		full  = count >= cfg.length;
		start = HeldW'(count - cfg.length);
		emit  = count - cfg.length + CountW'(1);
		idx   = '0;
		off   = '0;
		for (int j = 0; j < MaxPattern; j++)
			wr[j] = (HeldW'(j) == held_q) ? byte_s1 : win_q[j];
		for (int i = 0; i < MaxPattern; i++) begin
			idx    = start + HeldW'(i);
			neq[i] = (CountW'(i) < cfg.length) && (wr[idx] != cfg.pattern[i]);
		end
		match = full && (neq == '0);
		for (int j = 0; j < MaxPattern; j++) begin
			off   = HeldW'(j) - start;
			nw[j] = (match && HeldW'(j) >= start && CountW'(j) < count) ?
				cfg.replace[off] : wr[j];
		end
		for (int j = 0; j < MaxPattern; j++) begin
			idx   = HeldW'(j) + emit[HeldW-1:0];
			sh[j] = nw[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (load) begin
			priority if (last_s1)
				held_q <= '0;
			else if (!full)
				held_q <= count[HeldW-1:0];
			else
				held_q <= HeldW'(cfg.length - CountW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			win_q <= (full && !last_s1) ? sh : wr;
	end

	always_comb begin
		burst.valid = load;
		burst.bytes = nw;
		burst.last  = last_s1;
		priority if (last_s1)
			burst.count = count;
		else if (full)
			burst.count = emit;
		else
			burst.count = '0;
	end

endmodule

// ===== design/spsub_obuf.sv =====
// Output register bank: holds one burst and shifts it out a byte per transaction.
// Depends on spsub_pkg.
module spsub_obuf import spsub_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  burst_t    burst,
	output logic      obuf_free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [MaxPattern-1:0][7:0] buf_q;
	logic [CountW-1:0] rem_q;
	logic              last_q;
	logic              pop;

	assign out_valid         = rem_q != '0;
	assign pop               = out_valid && out_ready;
	assign obuf_free         = (rem_q == '0) || (rem_q == CountW'(1) && out_ready);
	assign out_data.out_byte = buf_q[0];
	assign out_data.out_last = last_q && rem_q == CountW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rem_q <= '0;
		else if (burst.valid)
			rem_q <= burst.count;
		else if (pop)
			rem_q <= rem_q - CountW'(1);
	end

	always_ff @(posedge clk) begin
		if (burst.valid) begin
			buf_q  <= burst.bytes;
			last_q <= burst.last;
		end else if (pop) begin
			for (int j = 0; j < MaxPattern - 1; j++)
				buf_q[j] <= buf_q[j+1];
		end
	end

endmodule

// ===== design/stream_pattern_substitute.sv =====
// Stream pattern substitute top level: APB registers, window core, output bank.
// Each input byte is registered in the core's input register, its output bytes in the
// output register bank. Throughput: 1 byte per cycle unless out_ready or a flush stalls;
// a flush drains through the bank, which takes a new burst as its last byte leaves.
// Reset (arst_n low): registers to pattern 0, length 1; window empty, outputs idle.
// Depends on spsub_pkg, spsub_cfg, spsub_core, spsub_obuf.
module stream_pattern_substitute import spsub_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	cfg_t   cfg;
	burst_t burst;
	logic   obuf_free;

	spsub_cfg u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cfg(cfg)
	);

	spsub_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.cfg(cfg), .obuf_free(obuf_free), .burst(burst)
	);

	spsub_obuf u_obuf (
		.clk(clk), .arst_n(arst_n),
		.burst(burst), .obuf_free(obuf_free),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	a_burst_fits: assert property (@(posedge clk) disable iff (!arst_n)
		burst.valid |-> burst.count <= CountW'(MaxPattern))
		else $error("burst longer than window");

	a_burst_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		burst.valid |-> obuf_free)
		else $error("burst loaded over pending output");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		burst.valid && burst.last |-> burst.count != '0)
		else $error("flush produced no bytes");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_last && !out_ready |=> out_valid && out_data.out_last)
		else $error("final byte lost before transaction");

endmodule
